FILE: rtl/core/bace_pkg.sv
// ----------------------------------------------------------------------------
// bace_pkg
// shared types and constants of the carry-less binary arithmetic encoder
// ----------------------------------------------------------------------------
package bace_pkg;

	// coder sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SHIFT,
		ST_FLUSH
	} front_state_t;

	// one byte on its way from the coder to the escape stage
	typedef struct packed {
		logic [7:0] data;
		logic       esc;   // byte goes through escaping; clear for the raw terminator
		logic       last;  // final byte of its item
	} byte_entry_t;

	// operation codes
	localparam logic OP_CODE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// byte values
	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic [7:0] BYTE_FE = 8'hFE;
	localparam logic [7:0] BYTE_FD = 8'hFD;

	// interval after reset and after a flush
	localparam logic [31:0] LOW_INIT  = 32'h0000_0000;
	localparam logic [31:0] HIGH_INIT = 32'hFFFF_FFFF;

	// step counter codes
	localparam logic [1:0] SHIFT_FIRST = 2'd0;
	localparam logic [1:0] SHIFT_FINAL = 2'd3;
	localparam logic [1:0] FL_LOW_BYTE = 2'd0;
	localparam logic [1:0] FL_TERM_A   = 2'd1;
	localparam logic [1:0] FL_TERM_B   = 2'd2;

endpackage

FILE: rtl/core/bace_fifo.sv
// ----------------------------------------------------------------------------
// bace_fifo
// short byte queue between the coder and the escape stage
// ----------------------------------------------------------------------------
module bace_fifo #(
	parameter int DEPTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bace_pkg::byte_entry_t  wr_entry,
	input  logic                   pop,
	output bace_pkg::byte_entry_t  rd_entry,
	output logic                   empty,
	output logic                   full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bace_pkg::byte_entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// the coder holds back while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("byte queue written while full");

	// the escape stage only takes a byte that is there
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("byte queue read while empty");

endmodule

FILE: rtl/core/bace_front.sv
// ----------------------------------------------------------------------------
// bace_front
// interval coder: splits the range, keeps the part for the bit and queues
// the settled leading bytes; a flush queues the low byte and the terminator
// ----------------------------------------------------------------------------
module bace_front #(
	parameter int PROB_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   operation,
	input  logic                   bit_value,
	input  logic [11:0]            probability,
	output logic                   push,
	output bace_pkg::byte_entry_t  push_entry,
	input  logic                   queue_full
);

	localparam int PB = PROB_BITS;

	bace_pkg::front_state_t state_q, state_d;

	logic [31:0]   low_q, high_q, span_q;
	logic [31:0]   hi_prod_s1;
	logic [PB-1:0] lo_prod_s1;
	logic          bit_s1;
	logic [1:0]    cnt_q;

	logic [31:0]   prob_ext;
	logic [PB-1:0] prob_m, prob_adj;
	logic [31:0]   hi_prod;
	logic [2*PB-1:0] lo_full;
	logic [31:0]   mid;
	logic          top_eq, next_eq, final_shift;
	logic [31:0]   low_shl, high_shl;
	logic          accept;
	logic          do_update, do_shift, do_flush_end;

	// probability masked to PB bits, raised by one below one half
	assign prob_ext = 32'(probability);
	assign prob_m   = prob_ext[PB-1:0];
	assign prob_adj = prob_m[PB-1] ? prob_m : prob_m + PB'(1);

	assign hi_prod = {{PB{1'b0}}, span_q[31:PB]} * {{(32-PB){1'b0}}, prob_adj};
	assign lo_full = {{PB{1'b0}}, span_q[PB-1:0]} * {{PB{1'b0}}, prob_adj};

	assign mid = low_q + hi_prod_s1 + {{(32-PB){1'b0}}, lo_prod_s1};

	assign top_eq      = (low_q[31:24] == high_q[31:24]);
	assign next_eq     = (low_q[23:16] == high_q[23:16]) && (cnt_q != bace_pkg::SHIFT_FINAL);
	assign final_shift = !next_eq;
	assign low_shl     = {low_q[23:0], 8'h00};
	assign high_shl    = {high_q[23:0], bace_pkg::BYTE_FF};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bace_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		item_ready   = 1'b0;
		push         = 1'b0;
		push_entry   = '{data: high_q[31:24], esc: 1'b1, last: final_shift};
		accept       = 1'b0;
		do_update    = 1'b0;
		do_shift     = 1'b0;
		do_flush_end = 1'b0;
		case (state_q)
			bace_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				accept     = item_valid;
				if (item_valid) begin
					state_d = (operation == bace_pkg::OP_FLUSH) ? bace_pkg::ST_FLUSH
						: bace_pkg::ST_UPDATE;
				end
			end
			bace_pkg::ST_UPDATE: begin
				do_update = 1'b1;
				state_d   = bace_pkg::ST_SHIFT;
			end
			bace_pkg::ST_SHIFT: begin
				if (!top_eq) begin
					state_d = bace_pkg::ST_IDLE;
				end else if (!queue_full) begin
					push     = 1'b1;
					do_shift = 1'b1;
					if (final_shift) begin
						state_d = bace_pkg::ST_IDLE;
					end
				end
			end
			bace_pkg::ST_FLUSH: begin
				case (cnt_q)
					bace_pkg::FL_LOW_BYTE:
						push_entry = '{data: low_q[31:24], esc: 1'b1, last: 1'b0};
					bace_pkg::FL_TERM_A:
						push_entry = '{data: bace_pkg::BYTE_FF, esc: 1'b0, last: 1'b0};
					default:
						push_entry = '{data: bace_pkg::BYTE_FF, esc: 1'b0, last: 1'b1};
				endcase
				if (!queue_full) begin
					push = 1'b1;
					if (cnt_q == bace_pkg::FL_TERM_B) begin
						do_flush_end = 1'b1;
						state_d      = bace_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = bace_pkg::ST_IDLE;
		endcase
	end

	// products of the split, registered ahead of the interval update
	always_ff @(posedge clk) begin
		if (accept) begin
			hi_prod_s1 <= hi_prod;
			lo_prod_s1 <= lo_full[2*PB-1:PB];
			bit_s1     <= bit_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= bace_pkg::LOW_INIT;
			high_q <= bace_pkg::HIGH_INIT;
			span_q <= bace_pkg::HIGH_INIT - bace_pkg::LOW_INIT;
			cnt_q  <= bace_pkg::SHIFT_FIRST;
		end else begin
			if (accept) begin
				cnt_q <= bace_pkg::SHIFT_FIRST;
			end
			if (do_update) begin
				if (bit_s1) begin
					high_q <= mid;
				end else begin
					low_q <= mid + 32'd1;
				end
				cnt_q <= bace_pkg::SHIFT_FIRST;
			end
			if (state_q == bace_pkg::ST_SHIFT) begin
				if (do_shift) begin
					low_q  <= low_shl;
					high_q <= high_shl;
					span_q <= high_shl - low_shl;
					cnt_q  <= cnt_q + 2'd1;
				end else begin
					span_q <= high_q - low_q;
				end
			end
			if ((state_q == bace_pkg::ST_FLUSH) && push) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (do_flush_end) begin
				low_q  <= bace_pkg::LOW_INIT;
				high_q <= bace_pkg::HIGH_INIT;
				span_q <= bace_pkg::HIGH_INIT - bace_pkg::LOW_INIT;
			end
		end
	end

	// nothing is queued while the coder waits for an item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bace_pkg::ST_IDLE) |-> !push)
		else $error("byte queued while coder idle");

endmodule

FILE: rtl/core/bace_back.sv
// ----------------------------------------------------------------------------
// bace_back
// escape stage and output register
// ----------------------------------------------------------------------------
module bace_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bace_pkg::byte_entry_t  head,
	input  logic                   queue_empty,
	output logic                   pop,
	output logic                   byte_valid,
	input  logic                   byte_ready,
	output logic [7:0]             out_byte,
	output logic                   last
);

	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       pend_v_q;
	logic [7:0] pend_byte_q;
	logic       pend_last_q;
	logic       esc_pend_q;

	logic       load_ok;
	logic [7:0] first_byte, second_byte;
	logic       two_bytes, esc_next;

	assign load_ok = !out_v_q || byte_ready;
	assign pop     = load_ok && !pend_v_q && !queue_empty;

	always_comb begin
		first_byte  = head.data;
		second_byte = bace_pkg::BYTE_FE;
		two_bytes   = 1'b0;
		esc_next    = 1'b0;
		if (head.esc) begin
			if ((head.data == bace_pkg::BYTE_FF) && !esc_pend_q) begin
				esc_next = 1'b1;
			end else if (head.data == bace_pkg::BYTE_FF) begin
				first_byte  = bace_pkg::BYTE_FE;
				second_byte = bace_pkg::BYTE_FE;
				two_bytes   = 1'b1;
			end else if ((head.data == bace_pkg::BYTE_FE) && esc_pend_q) begin
				first_byte  = bace_pkg::BYTE_FE;
				second_byte = bace_pkg::BYTE_FD;
				two_bytes   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_v_q) begin
				out_byte_q <= pend_byte_q;
				out_last_q <= pend_last_q;
			end else begin
				out_byte_q <= first_byte;
				out_last_q <= head.last && !two_bytes;
			end
		end
		if (pop) begin
			pend_byte_q <= second_byte;
			pend_last_q <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			esc_pend_q <= 1'b0;
		end else begin
			if (load_ok) begin
				if (pend_v_q) begin
					out_v_q  <= 1'b1;
					pend_v_q <= 1'b0;
				end else begin
					out_v_q  <= !queue_empty;
					pend_v_q <= !queue_empty && two_bytes;
				end
			end
			if (pop) begin
				esc_pend_q <= esc_next;
			end
		end
	end

	assign byte_valid = out_v_q;
	assign out_byte   = out_byte_q;
	assign last       = out_last_q;

	// the second byte of an escape only waits behind a byte on the port
	assert property (@(posedge clk) disable iff (!arst_n) pend_v_q |-> out_v_q)
		else $error("escape byte pending with empty output register");

endmodule

FILE: rtl/core/binary_arithmetic_encoder_stuffed.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_stuffed
// carry-less 32-bit binary arithmetic encoder with escaped byte output
// ----------------------------------------------------------------------------
// item channel: item_valid / item_ready with operation, bit_value and
// probability; a code beat narrows the interval for one bit, a flush beat
// ends the chunk with the top byte of low and the raw terminator ff ff
// byte channel: byte_valid / byte_ready with out_byte and last; last marks
// the final byte caused by an item, a code beat that settles no byte
// gives none
// sequence: a code beat takes the accept step (products), the interval
// update and then queues each settled byte, from none up to four; a flush
// queues the low byte and the two terminator bytes; the coder holds
// item_ready low meanwhile and stalls while the queue is full
// first byte path: product registers, interval update, queue, output register
// escaped ff / fe bytes go out as two bytes at the output
// a short byte queue parts coder and escape stage, so a stalled receiver
// only stops the coder once the queue is full; a waiting byte holds steady
// reset clears the interval to [0, ffffffff], the escape flag and the queue
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_stuffed #(
	parameter int PROB_BITS   = 12,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        operation,
	input  logic        bit_value,
	input  logic [11:0] probability,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	// coder to queue
	logic                  push;
	bace_pkg::byte_entry_t push_entry;
	logic                  queue_full;

	// queue to escape stage
	logic                  pop;
	bace_pkg::byte_entry_t head;
	logic                  queue_empty;

	// interval arithmetic and byte settling
	bace_front #(
		.PROB_BITS (PROB_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.operation  (operation),
		.bit_value  (bit_value),
		.probability(probability),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	// decoupling queue of settled bytes
	bace_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (head),
		.empty    (queue_empty),
		.full     (queue_full)
	);

	// escape stage, one byte per cycle to the port while byte_ready is high
	bace_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (queue_empty),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.out_byte    (out_byte),
		.last        (last)
	);

endmodule
